// ===== design/lfr_pkg.sv =====
// lfr_pkg: shared widths, operation and status codes, and the
// command/status structs between the line fit controller and datapath
// no dependencies
package lfr_pkg;

   localparam int COORD_W        = 16;
   localparam int MAX_POINTS_DEF = 4096;
   localparam int WORD_W         = 64;
   localparam int NUM_W          = 2 * WORD_W;
   localparam int FIX_W          = 32;
   localparam int ROUGH_W        = 31;
   localparam int STAT_W         = 2;

   typedef logic [3:0] op_type;

   // multiplier operations
   localparam op_type OP_NONE  = 4'd0;
   localparam op_type OP_NSXX  = 4'd1;
   localparam op_type OP_SXSX  = 4'd2;
   localparam op_type OP_NSXY  = 4'd3;
   localparam op_type OP_SXSY  = 4'd4;
   localparam op_type OP_BQSX  = 4'd5;
   localparam op_type OP_BQBQ  = 4'd6;
   localparam op_type OP_ND    = 4'd7;
   // divider operations
   localparam op_type DV_SLOPE = 4'd8;
   localparam op_type DV_ICPT  = 4'd9;
   localparam op_type DV_ROUGH = 4'd10;

   typedef logic [STAT_W-1:0] stat_type;

   localparam stat_type ST_OK    = 2'd0;
   localparam stat_type ST_NOPTS = 2'd1;
   localparam stat_type ST_VERT  = 2'd2;
   localparam stat_type ST_OVF   = 2'd3;

   typedef struct packed {
      logic     mul_start;
      logic     div_start;
      logic     sqrt_start;
      logic     pass_start;
      logic     load_out;
      op_type   op;
      stat_type status;
   } lfr_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic sqrt_done;
      logic pass_done;
      logic n_zero;
      logic ssxx_nonpos;
      logic out_busy;
   } lfr_sts_type;

endpackage

// ===== design/lfr_div.sv =====
// lfr_div: restoring divider, one quotient bit per cycle, 128-bit dividend,
// round to nearest with ties up, saturated 64-bit quotient
// depends on lfr_pkg
module lfr_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lfr_pkg::NUM_W-1:0]  num,
   input  logic [lfr_pkg::WORD_W-1:0] den,
   output logic                       done,
   output logic [lfr_pkg::WORD_W-1:0] quo
);
   import lfr_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0]  num_ff;
   logic [WORD_W-1:0] den_ff;
   logic [WORD_W-1:0] rem_ff;
   logic [WORD_W-1:0] q_ff;
   logic [WORD_W-1:0] quo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              over_ff;
   logic              run_ff;
   logic              rnd_ff;
   logic              done_ff;

   logic [WORD_W-1:0] rem_sh;
   logic [WORD_W-1:0] q_sh;
   logic              ge;
   logic              half;
   logic [WORD_W-1:0] quo_in;

   // one shift-subtract step
   always_comb begin
      rem_sh = {rem_ff[WORD_W-2:0], num_ff[NUM_W-1]};
      q_sh   = {q_ff[WORD_W-2:0], 1'b0};
      ge     = (rem_sh >= den_ff);
   end

   // final rounding and saturation
   always_comb begin
      half = (rem_ff >= (den_ff - rem_ff));
      if (over_ff || (half && (&q_ff))) begin
         quo_in = '1;
      end else begin
         quo_in = q_ff + WORD_W'(half);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         rnd_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            q_ff    <= '0;
            over_ff <= 1'b0;
            cnt_ff  <= '0;
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            num_ff <= {num_ff[NUM_W-2:0], 1'b0};
            rem_ff <= ge ? (rem_sh - den_ff) : rem_sh;
            q_ff   <= q_sh | WORD_W'(ge);
            if (q_ff[WORD_W-1]) begin
               over_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               run_ff <= 1'b0;
               rnd_ff <= 1'b1;
            end
         end else if (rnd_ff) begin
            rnd_ff  <= 1'b0;
            done_ff <= 1'b1;
            quo_ff  <= quo_in;
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== design/lfr_dp.sv =====
// lfr_dp: point store, running sums, shared serial multiplier, square root,
// residual pass and result register of the line fit
// depends on lfr_pkg and lfr_div
module lfr_dp #(
   parameter int MAX_POINTS = lfr_pkg::MAX_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_accept,
   input  logic signed [lfr_pkg::COORD_W-1:0] point_x,
   input  logic signed [lfr_pkg::COORD_W-1:0] point_y,
   input  lfr_pkg::lfr_cmd_type               cmd,
   output lfr_pkg::lfr_sts_type               sts,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [lfr_pkg::ROUGH_W-1:0]        rsp_roughness,
   output logic signed [lfr_pkg::FIX_W-1:0]   rsp_intercept,
   output logic signed [lfr_pkg::FIX_W-1:0]   rsp_slope,
   output logic [lfr_pkg::STAT_W-1:0]         rsp_fit_status
);
   import lfr_pkg::*;

   localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int SXW   = COORD_W + CW;
   localparam int SXXW  = 2 * COORD_W + CW;
   localparam int SQW   = 2 * COORD_W;
   localparam int MCW   = $clog2(WORD_W);
   localparam int PRODW = FIX_W + COORD_W;

   function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] r;
      r = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
      return r;
   endfunction

   function automatic logic [FIX_W-1:0] sat32(input logic neg, input logic [WORD_W-1:0] m);
      logic [FIX_W-1:0] r;
      if (neg) begin
         r = (m >= (WORD_W'(1) << (FIX_W - 1))) ? {1'b1, {(FIX_W-1){1'b0}}}
                                                 : (~m[FIX_W-1:0] + FIX_W'(1));
      end else begin
         r = (m > WORD_W'({1'b0, {(FIX_W-1){1'b1}}})) ? {1'b0, {(FIX_W-1){1'b1}}}
                                                       : m[FIX_W-1:0];
      end
      return r;
   endfunction

   // point store
   logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
   logic signed [COORD_W-1:0] mem_y [MAX_POINTS];

   logic [CW-1:0]          count_ff;
   logic signed [SXW-1:0]  sum_x_ff;
   logic signed [SXW-1:0]  sum_y_ff;
   logic signed [SXXW-1:0] sum_xx_ff;
   logic signed [SXXW-1:0] sum_xy_ff;
   logic                   ovf_ff;
   logic                   room;

   logic signed [SQW-1:0] xx;
   logic signed [SQW-1:0] xy;

   // fit registers
   logic [WORD_W-1:0]       t1_ff;
   logic [WORD_W-1:0]       ssxx_ff;
   logic [WORD_W-1:0]       ssxy_ff;
   logic [WORD_W-1:0]       num_ff;
   logic [WORD_W-1:0]       sqv_ff;
   logic [WORD_W-1:0]       den3_ff;
   logic [WORD_W-1:0]       d_ff;
   logic signed [FIX_W-1:0] aq_ff;
   logic signed [FIX_W-1:0] bq_ff;
   logic [ROUGH_W-1:0]      rough_ff;

   // operands widened to the word
   logic [WORD_W-1:0] n64;
   logic [WORD_W-1:0] sx64;
   logic [WORD_W-1:0] sy64;
   logic [WORD_W-1:0] sxx64;
   logic [WORD_W-1:0] sxy64;
   logic [WORD_W-1:0] bq64;
   logic [WORD_W-1:0] aq64;

   assign room  = (count_ff < CW'(MAX_POINTS));
   assign xx    = SQW'(point_x) * SQW'(point_x);
   assign xy    = SQW'(point_x) * SQW'(point_y);
   assign n64   = WORD_W'(count_ff);
   assign sx64  = {{(WORD_W-SXW){sum_x_ff[SXW-1]}}, sum_x_ff};
   assign sy64  = {{(WORD_W-SXW){sum_y_ff[SXW-1]}}, sum_y_ff};
   assign sxx64 = {{(WORD_W-SXXW){sum_xx_ff[SXXW-1]}}, sum_xx_ff};
   assign sxy64 = {{(WORD_W-SXXW){sum_xy_ff[SXXW-1]}}, sum_xy_ff};
   assign bq64  = {{(WORD_W-FIX_W){bq_ff[FIX_W-1]}}, bq_ff};
   assign aq64  = {{(WORD_W-FIX_W){aq_ff[FIX_W-1]}}, aq_ff};

   // residual pass pipeline
   logic [AW-1:0]             rd_addr_ff;
   logic                      pass_run_ff;
   logic                      pass_busy_ff;
   logic                      pass_done_ff;
   logic                      v1_ff;
   logic                      v2_ff;
   logic signed [COORD_W-1:0] rd_x_ff;
   logic signed [COORD_W-1:0] rd_y_ff;
   logic signed [PRODW-1:0]   prod_ff;
   logic [WORD_W-1:0]         yt_ff;
   logic [WORD_W-1:0]         acc_ff;
   logic [AW-1:0]             last_addr;
   logic [WORD_W-1:0]         res;

   assign last_addr = AW'(count_ff - CW'(1));
   assign res       = yt_ff - {{(WORD_W-PRODW){prod_ff[PRODW-1]}}, prod_ff};

   // store writes and pass reads
   always_ff @(posedge clock) begin
      if (req_accept && room) begin
         mem_x[count_ff[AW-1:0]] <= point_x;
         mem_y[count_ff[AW-1:0]] <= point_y;
      end
      if (pass_run_ff) begin
         rd_x_ff <= mem_x[rd_addr_ff];
         rd_y_ff <= mem_y[rd_addr_ff];
      end
   end

   // count, sums and overflow flag
   always_ff @(posedge clock) begin
      if (reset || cmd.load_out) begin
         count_ff  <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_xx_ff <= '0;
         sum_xy_ff <= '0;
         ovf_ff    <= 1'b0;
      end else if (req_accept) begin
         if (room) begin
            count_ff  <= count_ff + CW'(1);
            sum_x_ff  <= sum_x_ff + {{(SXW-COORD_W){point_x[COORD_W-1]}}, point_x};
            sum_y_ff  <= sum_y_ff + {{(SXW-COORD_W){point_y[COORD_W-1]}}, point_y};
            sum_xx_ff <= sum_xx_ff + {{(SXXW-2*COORD_W){xx[2*COORD_W-1]}}, xx};
            sum_xy_ff <= sum_xy_ff + {{(SXXW-2*COORD_W){xy[2*COORD_W-1]}}, xy};
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   // shift-add multiplier, low word of the product
   logic [WORD_W-1:0] mul_a_ff;
   logic [WORD_W-1:0] mul_b_ff;
   logic [WORD_W-1:0] mul_p_ff;
   logic [MCW-1:0]    mul_cnt_ff;
   logic              mul_busy_ff;
   logic              mul_done_ff;
   op_type            mul_op_ff;
   logic [WORD_W-1:0] mul_p_in;
   logic [WORD_W-1:0] op_a;
   logic [WORD_W-1:0] op_b;

   assign mul_p_in = mul_b_ff[0] ? (mul_p_ff + mul_a_ff) : mul_p_ff;

   // multiplier operand select
   always_comb begin
      unique case (cmd.op)
         OP_NSXX: begin op_a = n64;  op_b = sxx64; end
         OP_SXSX: begin op_a = sx64; op_b = sx64;  end
         OP_NSXY: begin op_a = n64;  op_b = sxy64; end
         OP_SXSY: begin op_a = sx64; op_b = sy64;  end
         OP_BQSX: begin op_a = bq64; op_b = sx64;  end
         OP_BQBQ: begin op_a = bq64; op_b = bq64;  end
         OP_ND:   begin op_a = n64;  op_b = d_ff;  end
         default: begin op_a = '0;   op_b = '0;    end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
         mul_done_ff <= 1'b0;
      end else begin
         mul_done_ff <= 1'b0;
         if (cmd.mul_start) begin
            mul_a_ff    <= op_a;
            mul_b_ff    <= op_b;
            mul_p_ff    <= '0;
            mul_cnt_ff  <= '0;
            mul_op_ff   <= cmd.op;
            mul_busy_ff <= 1'b1;
         end else if (mul_busy_ff) begin
            mul_a_ff   <= {mul_a_ff[WORD_W-2:0], 1'b0};
            mul_b_ff   <= {1'b0, mul_b_ff[WORD_W-1:1]};
            mul_p_ff   <= mul_p_in;
            mul_cnt_ff <= mul_cnt_ff + MCW'(1);
            if (mul_cnt_ff == MCW'(WORD_W - 1)) begin
               mul_busy_ff <= 1'b0;
               mul_done_ff <= 1'b1;
               // product write-back
               unique case (mul_op_ff)
                  OP_NSXX: t1_ff   <= mul_p_in;
                  OP_SXSX: ssxx_ff <= t1_ff - mul_p_in;
                  OP_NSXY: t1_ff   <= mul_p_in;
                  OP_SXSY: ssxy_ff <= t1_ff - mul_p_in;
                  OP_BQSX: num_ff  <= (sy64 << 16) - mul_p_in;
                  OP_BQBQ: sqv_ff  <= mul_p_in + (WORD_W'(1) << 32);
                  OP_ND:   den3_ff <= mul_p_in;
                  default: t1_ff   <= t1_ff;
               endcase
            end
         end
      end
   end

   // divider operands
   logic [NUM_W-1:0]  div_num;
   logic [WORD_W-1:0] div_den;
   logic [WORD_W-1:0] div_quo;
   logic              div_done;
   op_type            div_op_ff;

   always_comb begin
      unique case (cmd.op)
         DV_SLOPE: begin
            div_num = {48'b0, mag(ssxy_ff), 16'b0};
            div_den = ssxx_ff;
         end
         DV_ICPT: begin
            div_num = {{WORD_W{1'b0}}, mag(num_ff)};
            div_den = n64 << 4;
         end
         DV_ROUGH: begin
            div_num = {52'b0, acc_ff, 12'b0};
            div_den = den3_ff;
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   lfr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // quotient write-back
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_op_ff <= cmd.op;
      end
      if (div_done) begin
         unique case (div_op_ff)
            DV_SLOPE: bq_ff <= sat32(ssxy_ff[WORD_W-1], div_quo);
            DV_ICPT:  aq_ff <= sat32(num_ff[WORD_W-1], div_quo);
            DV_ROUGH: rough_ff <= (div_quo > WORD_W'({ROUGH_W{1'b1}})) ? {ROUGH_W{1'b1}}
                                                                        : div_quo[ROUGH_W-1:0];
            default:  rough_ff <= rough_ff;
         endcase
      end
   end

   // integer square root, two bits per cycle, rounded
   logic [WORD_W-1:0] sq_v_ff;
   logic [WORD_W-1:0] sq_r_ff;
   logic [WORD_W-1:0] sq_bit_ff;
   logic              sq_busy_ff;
   logic              sq_done_ff;
   logic [WORD_W-1:0] sq_sum;

   assign sq_sum = sq_r_ff + sq_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
         sq_done_ff <= 1'b0;
      end else begin
         sq_done_ff <= 1'b0;
         if (cmd.sqrt_start) begin
            sq_v_ff    <= sqv_ff;
            sq_r_ff    <= '0;
            sq_bit_ff  <= WORD_W'(1) << (WORD_W - 2);
            sq_busy_ff <= 1'b1;
         end else if (sq_busy_ff) begin
            if (sq_bit_ff != '0) begin
               if (sq_v_ff >= sq_sum) begin
                  sq_v_ff <= sq_v_ff - sq_sum;
                  sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_r_ff <= sq_r_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
            end else begin
               d_ff       <= (sq_v_ff > sq_r_ff) ? (sq_r_ff + WORD_W'(1)) : sq_r_ff;
               sq_busy_ff <= 1'b0;
               sq_done_ff <= 1'b1;
            end
         end
      end
   end

   // residual pass: read, multiply, absolute sum
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_run_ff  <= 1'b0;
         pass_busy_ff <= 1'b0;
         pass_done_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         pass_done_ff <= 1'b0;
         v1_ff        <= pass_run_ff;
         v2_ff        <= v1_ff;
         if (cmd.pass_start) begin
            rd_addr_ff   <= '0;
            pass_run_ff  <= 1'b1;
            pass_busy_ff <= 1'b1;
            acc_ff       <= '0;
         end else begin
            if (pass_run_ff) begin
               rd_addr_ff <= rd_addr_ff + AW'(1);
               if (rd_addr_ff == last_addr) begin
                  pass_run_ff <= 1'b0;
               end
            end
            if (v1_ff) begin
               prod_ff <= PRODW'(bq_ff) * PRODW'(rd_x_ff);
               yt_ff   <= ({{(WORD_W-COORD_W){rd_y_ff[COORD_W-1]}}, rd_y_ff} << 16)
                          - (aq64 << 4);
            end
            if (v2_ff) begin
               acc_ff <= acc_ff + mag(res);
            end
            if (pass_busy_ff && !pass_run_ff && !v1_ff && !v2_ff) begin
               pass_busy_ff <= 1'b0;
               pass_done_ff <= 1'b1;
            end
         end
      end
   end

   // result register
   logic                    rsp_valid_ff;
   logic [ROUGH_W-1:0]      rsp_rough_ff;
   logic signed [FIX_W-1:0] rsp_icpt_ff;
   logic signed [FIX_W-1:0] rsp_slope_ff;
   stat_type                rsp_stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
         if (cmd.status == ST_OK) begin
            rsp_rough_ff <= rough_ff;
            rsp_icpt_ff  <= aq_ff;
            rsp_slope_ff <= bq_ff;
            rsp_stat_ff  <= ovf_ff ? ST_OVF : ST_OK;
         end else begin
            rsp_rough_ff <= '0;
            rsp_icpt_ff  <= '0;
            rsp_slope_ff <= '0;
            rsp_stat_ff  <= cmd.status;
         end
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_roughness  = rsp_rough_ff;
   assign rsp_intercept  = rsp_icpt_ff;
   assign rsp_slope      = rsp_slope_ff;
   assign rsp_fit_status = rsp_stat_ff;

   // status to the controller
   always_comb begin
      sts.mul_done    = mul_done_ff;
      sts.div_done    = div_done;
      sts.sqrt_done   = sq_done_ff;
      sts.pass_done   = pass_done_ff;
      sts.n_zero      = (count_ff == '0);
      sts.ssxx_nonpos = ssxx_ff[WORD_W-1] || (ssxx_ff == '0);
      sts.out_busy    = rsp_valid_ff && !rsp_ready;
   end

   // checks
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !mul_busy_ff)
      else $error("multiplier started while busy");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_out))
      else $error("result valid without a load");

   a_pass_addr: assert property (@(posedge clock) disable iff (reset)
      pass_run_ff |-> (CW'(rd_addr_ff) < count_ff))
      else $error("residual pass read beyond stored points");

endmodule

// ===== design/lfr_ctrl.sv =====
// lfr_ctrl: sequencer of the line fit, collects points and then steps the
// datapath through sums, slope, intercept, residual pass and scale
// depends on lfr_pkg
module lfr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  logic                 req_last_point,
   output logic                 req_ready,
   input  lfr_pkg::lfr_sts_type sts,
   output lfr_pkg::lfr_cmd_type cmd
);
   import lfr_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CHK0 = 4'd1;
   localparam logic [3:0] S_M1   = 4'd2;
   localparam logic [3:0] S_M2   = 4'd3;
   localparam logic [3:0] S_M3   = 4'd4;
   localparam logic [3:0] S_M4   = 4'd5;
   localparam logic [3:0] S_CHKX = 4'd6;
   localparam logic [3:0] S_DV1  = 4'd7;
   localparam logic [3:0] S_M5   = 4'd8;
   localparam logic [3:0] S_DV2  = 4'd9;
   localparam logic [3:0] S_PASS = 4'd10;
   localparam logic [3:0] S_M6   = 4'd11;
   localparam logic [3:0] S_SQ   = 4'd12;
   localparam logic [3:0] S_M7   = 4'd13;
   localparam logic [3:0] S_DV3  = 4'd14;
   localparam logic [3:0] S_OUT  = 4'd15;

   localparam logic [2:0] U_NONE = 3'd0;
   localparam logic [2:0] U_MUL  = 3'd1;
   localparam logic [2:0] U_DIV  = 3'd2;
   localparam logic [2:0] U_SQRT = 3'd3;
   localparam logic [2:0] U_PASS = 3'd4;

   logic [3:0] st_ff;
   logic [3:0] st_in;
   logic       iss_ff;
   logic       iss_in;
   stat_type   status_ff;
   stat_type   status_in;
   logic [2:0] unit;
   logic [3:0] nxt;
   logic       unit_done;

   always_comb begin
      cmd        = '0;
      cmd.status = status_ff;
      st_in      = st_ff;
      iss_in     = iss_ff;
      status_in  = status_ff;
      unit       = U_NONE;
      nxt        = st_ff;

      unique case (st_ff)
         S_IDLE: if (req_accept && req_last_point) st_in = S_CHK0;
         S_CHK0: begin
            if (sts.n_zero) begin
               status_in = ST_NOPTS;
               st_in     = S_OUT;
            end else begin
               st_in = S_M1;
            end
         end
         S_M1:   begin unit = U_MUL;  cmd.op = OP_NSXX;  nxt = S_M2;   end
         S_M2:   begin unit = U_MUL;  cmd.op = OP_SXSX;  nxt = S_M3;   end
         S_M3:   begin unit = U_MUL;  cmd.op = OP_NSXY;  nxt = S_M4;   end
         S_M4:   begin unit = U_MUL;  cmd.op = OP_SXSY;  nxt = S_CHKX; end
         S_CHKX: begin
            if (sts.ssxx_nonpos) begin
               status_in = ST_VERT;
               st_in     = S_OUT;
            end else begin
               status_in = ST_OK;
               st_in     = S_DV1;
            end
         end
         S_DV1:  begin unit = U_DIV;  cmd.op = DV_SLOPE; nxt = S_M5;   end
         S_M5:   begin unit = U_MUL;  cmd.op = OP_BQSX;  nxt = S_DV2;  end
         S_DV2:  begin unit = U_DIV;  cmd.op = DV_ICPT;  nxt = S_PASS; end
         S_PASS: begin unit = U_PASS; cmd.op = OP_NONE;  nxt = S_M6;   end
         S_M6:   begin unit = U_MUL;  cmd.op = OP_BQBQ;  nxt = S_SQ;   end
         S_SQ:   begin unit = U_SQRT; cmd.op = OP_NONE;  nxt = S_M7;   end
         S_M7:   begin unit = U_MUL;  cmd.op = OP_ND;    nxt = S_DV3;  end
         S_DV3:  begin unit = U_DIV;  cmd.op = DV_ROUGH; nxt = S_OUT;  end
         S_OUT: begin
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               st_in        = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase

      // unit done for the running step
      unique case (unit)
         U_MUL:   unit_done = sts.mul_done;
         U_DIV:   unit_done = sts.div_done;
         U_SQRT:  unit_done = sts.sqrt_done;
         U_PASS:  unit_done = sts.pass_done;
         default: unit_done = 1'b0;
      endcase

      // issue once, then wait for done
      if (unit != U_NONE) begin
         if (!iss_ff) begin
            iss_in         = 1'b1;
            cmd.mul_start  = (unit == U_MUL);
            cmd.div_start  = (unit == U_DIV);
            cmd.sqrt_start = (unit == U_SQRT);
            cmd.pass_start = (unit == U_PASS);
         end else if (unit_done) begin
            iss_in = 1'b0;
            st_in  = nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         iss_ff    <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         st_ff     <= st_in;
         iss_ff    <= iss_in;
         status_ff <= status_in;
      end
   end

   assign req_ready = (st_ff == S_IDLE);

endmodule

// ===== design/line_fit_roughness.sv =====
// line_fit_roughness: top level, least-squares line fit of a point set and
// mean perpendicular distance of the points to the fitted line
// depends on lfr_pkg, lfr_ctrl, lfr_dp
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  point_x, point_y, last_point
//  rsp      out        rsp_valid/rsp_ready  roughness, intercept, slope, fit_status
//
// points are taken one per cycle while req_ready is high; each is stored and
// added into the sums while the store has room, else it sets the overflow flag
// the point marked last starts the fit: seven serial multiplies, three serial
// divides, a square root, a pass over the point store and three check and load
// steps; a vertical fit answers before the slope divide
// req_ready is low during the fit; the result sits in an output register,
// so a new set may be collected while it waits for rsp_ready
// reset is synchronous and clears the count, the sums and all control state
module line_fit_roughness #(
   parameter int MAX_POINTS = lfr_pkg::MAX_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [lfr_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [lfr_pkg::COORD_W-1:0] req_point_y,
   input  logic                               req_last_point,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lfr_pkg::ROUGH_W-1:0]        rsp_roughness,
   output logic signed [lfr_pkg::FIX_W-1:0]   rsp_intercept,
   output logic signed [lfr_pkg::FIX_W-1:0]   rsp_slope,
   output logic [lfr_pkg::STAT_W-1:0]         rsp_fit_status
);
   import lfr_pkg::*;

   lfr_cmd_type cmd;
   lfr_sts_type sts;
   logic        req_accept;

   assign req_accept = req_valid && req_ready;

   lfr_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (req_accept),
      .req_last_point (req_last_point),
      .req_ready      (req_ready),
      .sts            (sts),
      .cmd            (cmd)
   );

   lfr_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (req_accept),
      .point_x        (req_point_x),
      .point_y        (req_point_y),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_roughness  (rsp_roughness),
      .rsp_intercept  (rsp_intercept),
      .rsp_slope      (rsp_slope),
      .rsp_fit_status (rsp_fit_status)
   );

endmodule

// ===== test/line_fit_roughness_tb.sv =====
// line_fit_roughness_tb: self-checking bench for the line fit roughness block
// predicts each fit in fixed point and compares every response transaction
// depends on lfr_pkg and line_fit_roughness
module line_fit_roughness_tb;
   import lfr_pkg::*;

   localparam int STORE_DEPTH = MAX_POINTS_DEF;
   localparam int STALL_LIMIT = 30000;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
      logic                      drain;
   } point_item_type;

   typedef struct {
      logic [ROUGH_W-1:0]      rough;
      logic signed [FIX_W-1:0] icpt;
      logic signed [FIX_W-1:0] slope;
      stat_type                status;
   } fit_result_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic signed [COORD_W-1:0]   req_point_x;
   logic signed [COORD_W-1:0]   req_point_y;
   logic                        req_last_point;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [ROUGH_W-1:0]          rsp_roughness;
   logic signed [FIX_W-1:0]     rsp_intercept;
   logic signed [FIX_W-1:0]     rsp_slope;
   logic [STAT_W-1:0]           rsp_fit_status;

   point_item_type pending_points[$];
   fit_result_type expected_fits[$];
   int             mismatch_count = 0;

   // predictor state
   logic signed [COORD_W-1:0] pts_x[STORE_DEPTH];
   logic signed [COORD_W-1:0] pts_y[STORE_DEPTH];
   int      pt_count = 0;
   longint  acc_x = 0, acc_y = 0, acc_xx = 0, acc_xy = 0;
   logic    store_overflow = 0;

   line_fit_roughness uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // rounded division, ties up, saturated to 64 bits
   function automatic logic [63:0] div_round(logic [127:0] num, logic [63:0] den);
      logic [127:0] q;
      logic [127:0] r;
      q = num / den;
      r = num % den;
      if (r >= den - r)
         q = q + 1;
      if (q[127:64] != 0)
         return '1;
      return q[63:0];
   endfunction

   function automatic logic [31:0] sat32(logic neg, logic [63:0] m);
      if (neg) begin
         if (m >= 64'h8000_0000)
            return 32'h8000_0000;
         return 32'(-m);
      end
      if (m > 64'h7FFF_FFFF)
         return 32'h7FFF_FFFF;
      return m[31:0];
   endfunction

   function automatic logic [63:0] sqrt_round(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= v)
            r = t;
      end
      if (v - r * r > r)
         r = r + 1;
      return r;
   endfunction

   function automatic logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // add a point to the model; returns 1 with the fit when the point is last
   function automatic bit fit_point(point_item_type p, output fit_result_type res);
      longint n, ssxx, ssxy, num, resid;
      logic [63:0] m, d, sum_abs;
      logic signed [31:0] aq, bq;
      res = '{default: 0};
      if (pt_count < STORE_DEPTH) begin
         pts_x[pt_count] = p.x;
         pts_y[pt_count] = p.y;
         pt_count++;
         acc_x += p.x;
         acc_y += p.y;
         acc_xx += longint'(p.x) * p.x;
         acc_xy += longint'(p.x) * p.y;
      end else
         store_overflow = 1;
      if (!p.last)
         return 0;
      n = pt_count;
      if (n == 0)
         res.status = ST_NOPTS;
      else begin
         ssxx = n * acc_xx - acc_x * acc_x;
         ssxy = n * acc_xy - acc_x * acc_y;
         if (ssxx <= 0)
            res.status = ST_VERT;
         else begin
            m = mag(ssxy);
            bq = sat32(ssxy < 0, div_round({64'd0, m} << 16, 64'(ssxx)));
            num = acc_y * 65536 - longint'(bq) * acc_x;
            aq = sat32(num < 0, div_round({64'd0, mag(num)}, 64'(16 * n)));
            sum_abs = 0;
            for (int i = 0; i < pt_count; i++) begin
               resid = longint'(pts_y[i]) * 65536 - longint'(aq) * 16
                       - longint'(bq) * pts_x[i];
               sum_abs += mag(resid);
            end
            m = mag(longint'(bq));
            d = sqrt_round(m * m + (64'd1 << 32));
            m = div_round({64'd0, sum_abs} << 12, 64'(n) * d);
            res.rough = m > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : m[30:0];
            res.icpt = aq;
            res.slope = bq;
            res.status = store_overflow ? ST_OVF : ST_OK;
         end
      end
      pt_count = 0;
      acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0;
      store_overflow = 0;
      return 1;
   endfunction

   function automatic int draw_gap();
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
   endfunction

   // request driver
   int             req_gap = 0;
   point_item_type req_cur;
   always @(posedge clock) begin
      fit_result_type res;
      logic           hold;
      if (reset) begin
         req_valid <= 0;
         req_point_x <= 0;
         req_point_y <= 0;
         req_last_point <= 0;
         req_gap = 0;
      end else begin
         hold = req_valid;
         if (req_valid && req_ready) begin
            if (fit_point(req_cur, res))
               expected_fits.insert(expected_fits.size(), res);
            hold = 0;
            req_gap = draw_gap();
         end
         if (!hold) begin
            if (req_gap > 0)
               req_gap--;
            else if (pending_points.size() > 0 &&
                     (!pending_points[0].drain || expected_fits.size() == 0)) begin
               req_cur = pending_points.pop_front();
               req_point_x <= req_cur.x;
               req_point_y <= req_cur.y;
               req_last_point <= req_cur.last;
               hold = 1;
            end
         end
         req_valid <= hold;
      end
   end

   // response monitor with random back-pressure
   int rsp_stall = 0;
   always @(posedge clock) begin
      fit_result_type want;
      if (reset) begin
         rsp_ready <= 0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_fits.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: rough=%0d icpt=%0d slope=%0d status=%0d",
                           rsp_roughness, rsp_intercept, rsp_slope, rsp_fit_status);
            end else begin
               want = expected_fits.pop_front();
               if (rsp_roughness !== want.rough || rsp_intercept !== want.icpt ||
                   rsp_slope !== want.slope || rsp_fit_status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp rough=%0d icpt=%0d slope=%0d status=%0d,",
                              want.rough, want.icpt, want.slope, want.status,
                              " got rough=%0d icpt=%0d slope=%0d status=%0d",
                              rsp_roughness, rsp_intercept, rsp_slope, rsp_fit_status);
               end
            end
            rsp_stall = draw_gap();
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // watchdog on cycles without any transaction
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[line_fit_roughness] ERROR");
         $finish;
      end
   end

   task automatic add_point(int x, int y, bit last, bit drain = 0);
      point_item_type p;
      p.x = COORD_W'(x);
      p.y = COORD_W'(y);
      p.last = last;
      p.drain = drain;
      pending_points.insert(pending_points.size(), p);
   endtask

   // one set of n points; shape picks full range, near-line or tiny spread
   task automatic add_set(int n, int shape);
      int a, b, x;
      a = $urandom_range(0, 4000) - 2000;
      b = $urandom_range(0, 16) - 8;
      for (int i = 0; i < n; i++) begin
         case (shape)
            0: add_point($urandom, $urandom, i == n - 1);
            1: begin
               x = $urandom_range(0, 2000) - 1000;
               add_point(x, a + b * x + $urandom_range(0, 64) - 32, i == n - 1);
            end
            default: add_point($urandom_range(0, 7) - 4, $urandom_range(0, 7) - 4, i == n - 1);
         endcase
      end
   endtask

   int sent;
   initial begin
      reset = 1;
      req_valid = 0;
      req_point_x = 0;
      req_point_y = 0;
      req_last_point = 0;
      rsp_ready = 0;
      // directed: single point, a vertical set, extremes, steep and flat lines
      add_point(16, 32, 1);
      add_point(-32768, 32767, 0);
      add_point(-32768, -32768, 1);
      add_point(-32768, 32767, 0);
      add_point(32767, -32768, 1);
      add_point(32767, 32767, 0);
      add_point(-32768, -32768, 1);
      add_point(0, -32768, 0);
      add_point(1, 32767, 1);
      add_point(0, 0, 0);
      add_point(16, 16, 0);
      add_point(32, 32, 1);
      add_point(-5, 100, 0);
      add_point(7, 100, 0);
      add_point(20, 100, 1, 1);
      add_point(100, 3, 0);
      add_point(-100, -7, 0);
      add_point(4, 1000, 0);
      add_point(-9, -1000, 1);
      repeat (7) @(posedge clock);
      reset <= 0;
      // random sets
      sent = 0;
      while (sent < 1250) begin
         int n;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 200) : $urandom_range(1, 24);
         add_set(n, $urandom_range(0, 2));
         sent += n;
      end
      wait (pending_points.size() == 0 && !req_valid && expected_fits.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_fits.size() == 0)
         $display("[line_fit_roughness] OK");
      else
         $display("[line_fit_roughness] ERROR");
      $finish;
   end
endmodule
